// ===== design/ofs_pkg.sv =====
package ofs_pkg;

   localparam int TABLE_ENTRIES_DEF = 65536;

   localparam int PRIME_W = 17;
   localparam int POWER_W = 8;
   localparam int SCALE_W = 8;
   localparam int EXP_W   = 12;
   localparam int PROD_W  = POWER_W + SCALE_W;

   localparam int MAX_RESULTS = 5;
   localparam int COUNT_W     = $clog2(MAX_RESULTS);

   localparam logic [PRIME_W-1:0] LIMIT_MAX = '1;
   localparam logic [EXP_W-1:0]   EXP_MAX   = '1;

   typedef enum logic {
      MODE_BUILD,
      MODE_FACTOR
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_DONE,
      STATUS_BAD,
      STATUS_UNBUILT
   } status_type;

   typedef struct packed {
      mode_type           mode;
      logic [PRIME_W-1:0] query_value;
      logic [SCALE_W-1:0] exponent_scale;
   } req_type;

   typedef struct packed {
      logic [PRIME_W-1:0] prime_factor;
      logic [EXP_W-1:0]   scaled_exponent;
      logic               last_of_run;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic               valid;
      logic [PRIME_W-1:0] prime;
      logic [EXP_W-1:0]   exponent;
      logic               last;
   } walk_result_type;

   typedef enum logic [1:0] {
      T_IDLE,
      T_BUILD,
      T_WALK
   } top_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CLEAR,
      B_PRIME_RD,
      B_PRIME_CHK,
      B_MULT_RD,
      B_MULT_CHK,
      B_COF_CHK
   } build_state_type;

   typedef enum logic [1:0] {
      W_IDLE,
      W_ISSUE,
      W_DATA
   } walk_state_type;

endpackage

// ===== design/ofs_ram.sv =====
module ofs_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ofs_build.sv =====
module ofs_build #(
   parameter  int TABLE_ENTRIES = ofs_pkg::TABLE_ENTRIES_DEF,
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES),
   localparam int ENTRY_W       = ofs_pkg::PRIME_W + ofs_pkg::POWER_W + ADDR_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ofs_pkg::PRIME_W-1:0] limit,
   output logic                        done,
   output logic                        rd_en,
   output logic [ADDR_W-1:0]           rd_addr,
   input  logic [ENTRY_W-1:0]          rd_data,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [ENTRY_W-1:0]          wr_data
);

   import ofs_pkg::*;

   localparam int CAND_W = PRIME_W + 1;  // odd candidate, may step past the limit
   localparam int MULT_W = PRIME_W + 2;  // multiple i*c, up to limit + 2i
   localparam int SUM_W  = PRIME_W + 3;

   build_state_type      state_ff, state_in;
   logic [PRIME_W-1:0]   lim_ff, lim_in;
   logic [CAND_W-1:0]    i_ff, i_in;
   logic [CAND_W-1:0]    sq_ff, sq_in;
   logic [MULT_W-1:0]    j_ff, j_in;
   logic [PRIME_W-1:0]   c_ff, c_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;

   logic [PRIME_W-1:0]   rd_prime;
   logic [POWER_W-1:0]   rd_power;
   logic [ADDR_W-1:0]    rd_link;
   logic [ADDR_W-1:0]    i_half, j_half, c_half, clr_last;
   logic [CAND_W-1:0]    i_step, sq_step;
   logic [SUM_W-1:0]     sq_sum;
   logic [MULT_W-1:0]    j_step;
   logic [PRIME_W-1:0]   c_step, prime_i;
   logic                 i_over, j_over, sq_fits, is_free, same_prime;

   assign rd_prime = rd_data[ENTRY_W-1 -: PRIME_W];
   assign rd_power = rd_data[ADDR_W +: POWER_W];
   assign rd_link  = rd_data[ADDR_W-1:0];

   assign i_half   = ADDR_W'(i_ff >> 1);
   assign j_half   = ADDR_W'(j_ff >> 1);
   assign c_half   = ADDR_W'(c_ff >> 1);
   assign clr_last = ADDR_W'(lim_ff >> 1);

   // (i+2)^2 = i^2 + 4i + 4, saturated once past any limit
   assign i_step  = i_ff + CAND_W'(2);
   assign sq_sum  = SUM_W'(sq_ff) + {i_ff, 2'b00} + SUM_W'(4);
   assign sq_step = (sq_sum > SUM_W'({CAND_W{1'b1}})) ? '1 : sq_sum[CAND_W-1:0];
   assign j_step  = j_ff + {i_ff, 1'b0};
   assign c_step  = c_ff + PRIME_W'(2);
   assign prime_i = i_ff[PRIME_W-1:0];

   assign i_over     = i_ff > CAND_W'(lim_ff);
   assign j_over     = j_ff > MULT_W'(lim_ff);
   assign sq_fits    = sq_ff <= CAND_W'(lim_ff);
   assign is_free    = rd_prime == '0;
   assign same_prime = rd_prime == prime_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      lim_ff <= lim_in;
      i_ff   <= i_in;
      sq_ff  <= sq_in;
      j_ff   <= j_in;
      c_ff   <= c_in;
      clr_ff <= clr_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (start) state_in = B_CLEAR;
         end
         B_CLEAR: begin
            if (clr_ff == clr_last) state_in = B_PRIME_RD;
         end
         B_PRIME_RD: begin
            state_in = i_over ? B_IDLE : B_PRIME_CHK;
         end
         B_PRIME_CHK: begin
            state_in = (is_free && sq_fits) ? B_MULT_RD : B_PRIME_RD;
         end
         B_MULT_RD: begin
            state_in = j_over ? B_PRIME_RD : B_MULT_CHK;
         end
         B_MULT_CHK: begin
            state_in = is_free ? B_COF_CHK : B_MULT_RD;
         end
         B_COF_CHK: begin
            state_in = B_MULT_RD;
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      lim_in = lim_ff;
      i_in   = i_ff;
      sq_in  = sq_ff;
      j_in   = j_ff;
      c_in   = c_ff;
      clr_in = clr_ff;
      case (state_ff)
         B_IDLE: begin
            if (start) begin
               lim_in = limit;
               clr_in = '0;
            end
         end
         B_CLEAR: begin
            clr_in = clr_ff + ADDR_W'(1);
            i_in   = CAND_W'(3);
            sq_in  = CAND_W'(9);
         end
         B_PRIME_CHK: begin
            if (is_free && sq_fits) begin
               j_in = MULT_W'(sq_ff);
               c_in = prime_i;
            end else begin
               i_in  = i_step;
               sq_in = sq_step;
            end
         end
         B_MULT_RD: begin
            if (j_over) begin
               i_in  = i_step;
               sq_in = sq_step;
            end
         end
         B_MULT_CHK: begin
            if (!is_free) begin
               j_in = j_step;
               c_in = c_step;
            end
         end
         B_COF_CHK: begin
            j_in = j_step;
            c_in = c_step;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      done    = 1'b0;
      rd_en   = 1'b0;
      rd_addr = i_half;
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      unique case (state_ff)
         B_IDLE: begin
         end
         B_CLEAR: begin
            wr_en = 1'b1;
         end
         B_PRIME_RD: begin
            done  = i_over;
            rd_en = !i_over;
         end
         B_PRIME_CHK: begin
            // unmarked candidate is prime: p^1, cofactor 1
            wr_en   = is_free;
            wr_addr = i_half;
            wr_data = {prime_i, POWER_W'(1), ADDR_W'(0)};
         end
         B_MULT_RD: begin
            rd_en   = !j_over;
            rd_addr = j_half;
         end
         B_MULT_CHK: begin
            rd_en   = is_free;
            rd_addr = c_half;
         end
         B_COF_CHK: begin
            // rd_data holds the entry of c = j / i
            wr_en   = 1'b1;
            wr_addr = j_half;
            wr_data = same_prime ? {prime_i, rd_power + POWER_W'(1), rd_link}
                                 : {prime_i, POWER_W'(1), c_half};
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/ofs_walk.sv =====
module ofs_walk #(
   parameter  int TABLE_ENTRIES = ofs_pkg::TABLE_ENTRIES_DEF,
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES),
   localparam int ENTRY_W       = ofs_pkg::PRIME_W + ofs_pkg::POWER_W + ADDR_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [ADDR_W-1:0]           start_index,
   input  logic [ofs_pkg::SCALE_W-1:0] scale,
   output logic                        rd_en,
   output logic [ADDR_W-1:0]           rd_addr,
   input  logic [ENTRY_W-1:0]          rd_data,
   output ofs_pkg::walk_result_type    result
);

   import ofs_pkg::*;

   walk_state_type       state_ff, state_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [SCALE_W-1:0]   scale_ff, scale_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic [PRIME_W-1:0]   rd_prime;
   logic [POWER_W-1:0]   rd_power;
   logic [ADDR_W-1:0]    rd_link;
   logic [PROD_W-1:0]    product;
   logic                 is_last;

   assign rd_prime = rd_data[ENTRY_W-1 -: PRIME_W];
   assign rd_power = rd_data[ADDR_W +: POWER_W];
   assign rd_link  = rd_data[ADDR_W-1:0];

   assign product = PROD_W'(rd_power) * PROD_W'(scale_ff);
   assign is_last = (rd_link == '0)
                 || ({1'b0, rd_link} >= (ADDR_W + 1)'(TABLE_ENTRIES))
                 || (count_ff == COUNT_W'(MAX_RESULTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff   <= idx_in;
      scale_ff <= scale_in;
      count_ff <= count_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         W_IDLE: begin
            if (start) state_in = W_ISSUE;
         end
         W_ISSUE: begin
            state_in = W_DATA;
         end
         W_DATA: begin
            if (is_last) state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      scale_in = scale_ff;
      count_in = count_ff;
      rd_en    = 1'b0;
      rd_addr  = idx_ff;
      result.valid    = 1'b0;
      result.prime    = (rd_prime != '0) ? rd_prime : PRIME_W'({idx_ff, 1'b1});
      result.exponent = (product > PROD_W'(EXP_MAX)) ? EXP_MAX : product[EXP_W-1:0];
      result.last     = is_last;
      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               idx_in   = start_index;
               scale_in = scale;
               count_in = '0;
            end
         end
         W_ISSUE: begin
            rd_en = 1'b1;
         end
         W_DATA: begin
            result.valid = 1'b1;
            // follow the cofactor link; data returns next cycle
            if (!is_last) begin
               rd_en    = 1'b1;
               rd_addr  = rd_link;
               idx_in   = rd_link;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== design/odd_factor_sieve_top.sv =====
// Channel   Handshake                  Payload                       Flow
// request   start / busy               req_data (ofs_pkg::req_type)  in
// result    rsp_strobe (1 cycle)       rsp_data (ofs_pkg::rsp_type)  out
// csr       csr_wr_en                  csr_wr_data (sieve_limit)     in
//
// Factor: results of a query come out back to back, one table read per chained entry.
// Error or unbuilt: answered the cycle after accept; value 1: no result. Busy stays low.
// Build: clears entries 0 to limit/2, then a read and a check per odd candidate and
//   per multiple, plus a cofactor read per new mark; all on the single table RAM.
// Reset leaves the table unbuilt; no RAM clearing runs after reset.
// Results cannot be stalled; each strobe lasts one cycle.
module odd_factor_sieve_top #(
   parameter int TABLE_ENTRIES = ofs_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  ofs_pkg::req_type            req_data,
   output logic                        rsp_strobe,
   output ofs_pkg::rsp_type            rsp_data,
   input  logic                        csr_wr_en,
   input  logic [ofs_pkg::PRIME_W-1:0] csr_wr_data
);

   import ofs_pkg::*;

   localparam int     ADDR_W  = $clog2(TABLE_ENTRIES);
   localparam int     ENTRY_W = PRIME_W + POWER_W + ADDR_W;
   localparam longint CAP     = 2 * longint'(TABLE_ENTRIES) - 1;
   localparam logic [PRIME_W-1:0] LIM_CAP =
      (CAP > longint'(LIMIT_MAX)) ? LIMIT_MAX : PRIME_W'(CAP);

   top_state_type        state_ff, state_in;
   logic [PRIME_W-1:0]   sieve_limit_ff, sieve_limit_in;
   logic                 built_ff, built_in;
   logic [PRIME_W-1:0]   built_limit_ff, built_limit_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 accept, is_build, query_bad, query_one;
   logic                 start_build, start_walk;
   logic [PRIME_W-1:0]   clip_limit;

   logic                 build_done;
   logic                 b_rd_en, w_rd_en, rd_en;
   logic [ADDR_W-1:0]    b_rd_addr, w_rd_addr, rd_addr;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]   wr_data, rd_data;
   walk_result_type      walk_res;

   assign accept      = start && !busy;
   assign is_build    = req_data.mode == MODE_BUILD;
   assign query_bad   = !req_data.query_value[0] || (req_data.query_value > built_limit_ff);
   assign query_one   = req_data.query_value == PRIME_W'(1);
   assign start_build = accept && is_build;
   assign start_walk  = accept && !is_build && built_ff && !query_bad && !query_one;
   assign clip_limit  = (sieve_limit_ff > LIM_CAP) ? LIM_CAP : sieve_limit_ff;

   ofs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ofs_build #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_build (
      .clock   (clock),
      .reset   (reset),
      .start   (start_build),
      .limit   (clip_limit),
      .done    (build_done),
      .rd_en   (b_rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   ofs_walk #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .start       (start_walk),
      .start_index (ADDR_W'(req_data.query_value >> 1)),
      .scale       (req_data.exponent_scale),
      .rd_en       (w_rd_en),
      .rd_addr     (w_rd_addr),
      .rd_data     (rd_data),
      .result      (walk_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_IDLE;
         sieve_limit_ff <= LIMIT_MAX;
         built_ff       <= 1'b0;
         built_limit_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sieve_limit_ff <= sieve_limit_in;
         built_ff       <= built_in;
         built_limit_ff <= built_limit_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (start_build) begin
               state_in = T_BUILD;
            end else if (start_walk) begin
               state_in = T_WALK;
            end
         end
         T_BUILD: begin
            if (build_done) state_in = T_IDLE;
         end
         T_WALK: begin
            if (walk_res.valid && walk_res.last) state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_comb begin
      busy    = state_ff != T_IDLE;
      rd_en   = (state_ff == T_WALK) ? w_rd_en : b_rd_en;
      rd_addr = (state_ff == T_WALK) ? w_rd_addr : b_rd_addr;
   end

   always_comb begin
      sieve_limit_in = csr_wr_en ? csr_wr_data : sieve_limit_ff;
      // no query can reach the table until the build transaction ends
      built_in       = built_ff || start_build;
      built_limit_in = start_build ? clip_limit : built_limit_ff;

      rsp_strobe_in         = 1'b0;
      rsp_in.prime_factor    = '0;
      rsp_in.scaled_exponent = '0;
      rsp_in.last_of_run     = 1'b1;
      rsp_in.status          = STATUS_OK;
      if (walk_res.valid) begin
         rsp_strobe_in          = 1'b1;
         rsp_in.prime_factor    = walk_res.prime;
         rsp_in.scaled_exponent = walk_res.exponent;
         rsp_in.last_of_run     = walk_res.last;
      end else if (build_done) begin
         rsp_strobe_in = 1'b1;
         rsp_in.status = STATUS_DONE;
      end else if (accept && !is_build) begin
         if (!built_ff) begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = STATUS_UNBUILT;
         end else if (query_bad) begin
            rsp_strobe_in = 1'b1;
            rsp_in.status = STATUS_BAD;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import ofs_pkg::*;

   localparam int          SIEVE_DEPTH = TABLE_ENTRIES_DEF;
   localparam int unsigned VALUE_TOP   = 131071;
   localparam int          SETTLE      = 8;
   // a full-size build gives no transaction until it ends, so the watchdog must outlast it
   localparam int          WATCHDOG    = 3000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_wr_en = 1'b0;
   logic [PRIME_W-1:0] csr_wr_data = '0;

   // predictor state
   logic [PRIME_W-1:0] spf_tab  [SIEVE_DEPTH];
   logic [POWER_W-1:0] pow_tab  [SIEVE_DEPTH];
   logic [15:0]        link_tab [SIEVE_DEPTH];
   bit                 table_ready = 1'b0;
   int unsigned        built_top = 0;
   int unsigned        limit_setting = VALUE_TOP;

   req_type     job_q[$];
   rsp_type     answer_q[$];
   int          mismatch_count = 0;
   int          gap_left = 0;
   int          burst_left = 0;
   int          quiet_cycles = 0;
   rsp_type     want;

   odd_factor_sieve_top uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic sieve_build();
      longint lim, i, c, ih, jh, ch;
      int     n;
      lim = limit_setting;
      if (lim > 2 * SIEVE_DEPTH - 1) lim = 2 * SIEVE_DEPTH - 1;
      for (n = 0; n < SIEVE_DEPTH; n++) begin
         spf_tab[n]  = '0;
         pow_tab[n]  = '0;
         link_tab[n] = '0;
      end
      for (i = 3; i <= lim; i += 2) begin
         ih = i >> 1;
         if (spf_tab[ih] != 0) continue;
         spf_tab[ih]  = PRIME_W'(i);
         pow_tab[ih]  = POWER_W'(1);
         link_tab[ih] = '0;
         for (c = i; i * c <= lim; c += 2) begin
            jh = (i * c) >> 1;
            ch = c >> 1;
            if (spf_tab[jh] != 0) continue;
            spf_tab[jh] = PRIME_W'(i);
            if (spf_tab[ch] == i) begin
               pow_tab[jh]  = pow_tab[ch] + POWER_W'(1);
               link_tab[jh] = link_tab[ch];
            end else begin
               pow_tab[jh]  = POWER_W'(1);
               link_tab[jh] = 16'(ch);
            end
         end
      end
      built_top   = int'(lim);
      table_ready = 1'b1;
   endtask

   // expected answers for one accepted transaction
   task automatic sieve_answer(input req_type item);
      rsp_type a;
      longint  idx, nxt, prod;
      int      k;
      bit      fin;
      a = '0;
      a.last_of_run = 1'b1;
      if (item.mode == MODE_BUILD) begin
         sieve_build();
         a.status = STATUS_DONE;
         answer_q.push_back(a);
      end else if (!table_ready) begin
         a.status = STATUS_UNBUILT;
         answer_q.push_back(a);
      end else if (!item.query_value[0] || item.query_value > built_top) begin
         a.status = STATUS_BAD;
         answer_q.push_back(a);
      end else begin
         idx = item.query_value >> 1;
         k   = 0;
         while (idx != 0 && idx < SIEVE_DEPTH && k < MAX_RESULTS) begin
            nxt  = link_tab[idx];
            prod = longint'(pow_tab[idx]) * item.exponent_scale;
            a.prime_factor    = (spf_tab[idx] != 0) ? spf_tab[idx] : PRIME_W'(2 * idx + 1);
            a.scaled_exponent = (prod > EXP_MAX) ? EXP_MAX : EXP_W'(prod);
            fin = (nxt == 0 || nxt >= SIEVE_DEPTH || k == MAX_RESULTS - 1);
            a.last_of_run = fin;
            a.status      = STATUS_OK;
            answer_q.push_back(a);
            k++;
            if (fin) break;
            idx = nxt;
         end
      end
   endtask

   function automatic int idle_draw();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(5, 30);
      return $urandom_range(0, 13);
   endfunction

   // driver: one transaction in flight, start held until busy drops
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            sieve_answer(req_data);
            gap_left = idle_draw();
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (job_q.size() != 0) begin
            req_data <= job_q.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic field_check(input string name, input logic [31:0] got,
                              input logic [31:0] exp_val);
      if (got !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = answer_q.pop_front();
            field_check("prime_factor", rsp_data.prime_factor, want.prime_factor);
            field_check("scaled_exponent", rsp_data.scaled_exponent, want.scaled_exponent);
            field_check("last_of_run", rsp_data.last_of_run, want.last_of_run);
            field_check("status", rsp_data.status, want.status);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   task automatic push_factor(input int unsigned v, input int unsigned s);
      req_type r;
      r.mode           = MODE_FACTOR;
      r.query_value    = PRIME_W'(v);
      r.exponent_scale = SCALE_W'(s);
      job_q.push_back(r);
   endtask

   task automatic push_build();
      req_type r;
      r                = '0;
      r.mode           = MODE_BUILD;
      r.query_value    = PRIME_W'($urandom_range(0, VALUE_TOP));
      r.exponent_scale = SCALE_W'($urandom_range(0, 255));
      job_q.push_back(r);
   endtask

   // wait until every transaction is out and every answer is back
   task automatic settle();
      do @(negedge clock);
      while (job_q.size() != 0 || start || answer_q.size() != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_limit(input int unsigned v);
      @(posedge clock);
      csr_wr_en     <= 1'b1;
      csr_wr_data   <= PRIME_W'(v);
      limit_setting = v & VALUE_TOP;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int unsigned smooth_odd(input int unsigned top);
      int unsigned primes [8];
      int unsigned v, p;
      primes = '{3, 5, 7, 11, 13, 17, 19, 23};
      v = 1;
      repeat ($urandom_range(1, 9)) begin
         p = primes[$urandom_range(0, 7)];
         if (v * p <= top) v = v * p;
      end
      return v;
   endfunction

   function automatic int unsigned scale_draw();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 255;
         default: return $urandom_range(1, 255);
      endcase
   endfunction

   task automatic random_burst(input int count, input int unsigned top, input bit with_builds);
      int unsigned pick, v;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (with_builds && pick < 3) begin
            push_build();
         end else begin
            if (pick < 50)      v = $urandom_range(0, top) | 1;
            else if (pick < 78) v = smooth_odd(top);
            else if (pick < 88) v = $urandom_range(0, VALUE_TOP) & ~32'd1;
            else if (pick < 94) v = (top < VALUE_TOP - 1) ? $urandom_range(top + 1, VALUE_TOP)
                                                          : VALUE_TOP - 1;
            else                v = $urandom_range(0, VALUE_TOP);
            push_factor(v, scale_draw());
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // nothing built yet
      push_factor(0, 1);
      push_factor(1, 0);
      push_factor(3, 255);
      push_factor(VALUE_TOP, 17);
      settle();

      // full table
      write_limit(VALUE_TOP);
      push_build();
      push_factor(3, 1);
      push_factor(VALUE_TOP, 255);
      push_factor(59049, 255);       // 3^10, scaled exponent 2550 stays below saturation
      push_factor(15015, 7);         // five distinct primes
      push_factor(7875, 200);
      push_factor(1, 9);
      push_factor(0, 3);
      push_factor(VALUE_TOP - 1, 3);
      push_factor(45, 0);
      random_burst(170, VALUE_TOP, 1'b0);
      settle();

      // limit of three, then a write with no rebuild: the latched limit holds
      write_limit(3);
      push_build();
      push_factor(3, 4);
      push_factor(5, 4);
      push_factor(1, 4);
      push_factor(4, 4);
      settle();
      write_limit(1001);
      push_factor(999, 2);
      push_factor(3, 2);
      settle();

      // limits below three still mark the table built
      write_limit(0);
      push_build();
      push_factor(1, 5);
      push_factor(3, 5);
      settle();
      write_limit(1);
      push_build();
      push_factor(1, 5);
      push_factor(3, 5);
      settle();
      write_limit(2000);
      push_build();
      push_factor(1999, 3);
      push_factor(2001, 3);
      settle();

      write_limit(3);
      push_build();
      random_burst(30, 3, 1'b1);
      settle();

      write_limit($urandom_range(3, 8191));
      push_build();
      random_burst(120, limit_setting, 1'b1);
      settle();

      write_limit($urandom_range(8192, 20000));
      push_build();
      random_burst(90, limit_setting, 1'b0);
      settle();

      if (mismatch_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
